// File: hdl/ssem_pkg.sv
// ssem_pkg: shared types and constants for the small-scale experimental machine core
// holds word and line widths, action and function codes, engine states, store request
// no dependencies
package ssem_pkg;

	localparam int WORD_BITS   = 32;
	localparam int STORE_WORDS = 32;
	localparam int LINE_BITS   = $clog2(STORE_WORDS);
	localparam int FUNC_LSB    = 13;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [LINE_BITS-1:0] line_t;

	typedef enum logic [1:0] {
		ACT_WRITE   = 2'd0,
		ACT_READ    = 2'd1,
		ACT_EXEC    = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_JMP  = 3'd0,
		OP_JRP  = 3'd1,
		OP_LDN  = 3'd2,
		OP_STO  = 3'd3,
		OP_SUB  = 3'd4,
		OP_SUBX = 3'd5,
		OP_CMP  = 3'd6,
		OP_STP  = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_OPER  = 4'b1000
	} state_t;

	typedef struct packed {
		logic  rd_en;
		line_t rd_addr;
		logic  wr_en;
		line_t wr_addr;
		word_t wr_data;
	} store_req_t;

endpackage

// File: hdl/ssem_store.sv
// ssem_store: main store, one write and one registered read port per cycle
// per-line valid bits make unwritten lines read as zero after reset
// depends on ssem_pkg
module ssem_store import ssem_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output word_t      rd_word
);

	word_t                  mem [STORE_WORDS];
	logic [STORE_WORDS-1:0] vld_q;
	word_t                  rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	// read data holds until the next read is issued
	assign rd_word = rd_vld_q ? rd_data_q : '0;

endmodule

// File: hdl/ssem_processor.sv
// ssem_processor: top level of the small-scale experimental machine core
// one-item input buffer, sequencer around the store memory, output register
// depends on ssem_pkg and ssem_store
//
//  channel  handshake            payload
//  in       in_valid / in_ready  action, address, write_word
//  out      out_valid / out_ready word_out, accumulator_out, instruction_pointer, halted
//
// write, restart and halted execute finish in idle, read finishes in the read state;
// a running execute fetches at ci+1, reads the operand, then executes and writes back,
// in the idle, fetch and oper states, set by the single read port of the store.
// one item waits in the input buffer while the previous one is at work.
// reset clears the control registers and store valid bits; restart keeps the store.
// a full output register that is not taken stalls the sequencer at its last step.
module ssem_processor import ssem_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [LINE_BITS-1:0]       address,
	input  logic [WORD_BITS-1:0]       write_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [WORD_BITS-1:0]       word_out,
	output logic signed [WORD_BITS-1:0] accumulator_out,
	output logic [LINE_BITS-1:0]       instruction_pointer,
	output logic                       halted
);

	logic       pend_q;
	action_t    pact_q;
	line_t      paddr_q;
	word_t      pword_q;

	state_t     state_q, state_n;
	word_t      acc_q, acc_n;
	line_t      ci_q, ci_n;
	logic       stop_q, stop_n;
	word_t      instr_q;

	logic       out_valid_q;
	word_t      word_out_q;
	word_t      acc_out_q;
	line_t      ci_out_q;
	logic       halted_q;

	store_req_t st_req;
	word_t      st_word;
	word_t      res_word;
	logic       out_free;
	logic       take;
	logic       done;
	func_t      func;

	ssem_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (st_req),
		.rd_word (st_word)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !pend_q || take;
	assign func     = func_t'(instr_q[FUNC_LSB +: 3]);

	always_comb begin
		state_n  = state_q;
		acc_n    = acc_q;
		ci_n     = ci_q;
		stop_n   = stop_q;
		res_word = '0;
		take     = 1'b0;
		done     = 1'b0;
		st_req   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (pend_q) begin
					unique case (pact_q)
						ACT_WRITE: begin
							if (out_free) begin
								take           = 1'b1;
								done           = 1'b1;
								st_req.wr_en   = 1'b1;
								st_req.wr_addr = paddr_q;
								st_req.wr_data = pword_q;
							end
						end
						ACT_READ: begin
							take           = 1'b1;
							st_req.rd_en   = 1'b1;
							st_req.rd_addr = paddr_q;
							state_n        = ST_READ;
						end
						ACT_EXEC: begin
							if (stop_q) begin
								if (out_free) begin
									take = 1'b1;
									done = 1'b1;
								end
							end else begin
								take           = 1'b1;
								ci_n           = ci_q + 1'b1;
								st_req.rd_en   = 1'b1;
								st_req.rd_addr = ci_n;
								state_n        = ST_FETCH;
							end
						end
						ACT_RESTART: begin
							if (out_free) begin
								take   = 1'b1;
								done   = 1'b1;
								acc_n  = '0;
								ci_n   = '0;
								stop_n = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					done     = 1'b1;
					res_word = st_word;
					state_n  = ST_IDLE;
				end
			end
			ST_FETCH: begin
				// operand line comes straight from the fetched word
				st_req.rd_en   = 1'b1;
				st_req.rd_addr = st_word[LINE_BITS-1:0];
				state_n        = ST_OPER;
			end
			ST_OPER: begin
				if (out_free) begin
					done     = 1'b1;
					res_word = instr_q;
					state_n  = ST_IDLE;
					unique case (func)
						OP_JMP:  ci_n = st_word[LINE_BITS-1:0];
						OP_JRP:  ci_n = ci_q + st_word[LINE_BITS-1:0];
						OP_LDN:  acc_n = '0 - st_word;
						OP_STO: begin
							st_req.wr_en   = 1'b1;
							st_req.wr_addr = instr_q[LINE_BITS-1:0];
							st_req.wr_data = acc_q;
						end
						OP_SUB, OP_SUBX: acc_n = acc_q - st_word;
						OP_CMP: begin
							if (acc_q[WORD_BITS-1]) begin
								ci_n = ci_q + 1'b1;
							end
						end
						OP_STP:  stop_n = 1'b1;
						default: ;
					endcase
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			ci_q        <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pend_q <= 1'b1;
			end else if (take) begin
				pend_q <= 1'b0;
			end
			state_q <= state_n;
			acc_q   <= acc_n;
			ci_q    <= ci_n;
			stop_q  <= stop_n;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pact_q  <= action_t'(action);
			paddr_q <= address;
			pword_q <= write_word;
		end
		if (state_q == ST_FETCH) begin
			instr_q <= st_word;
		end
		if (done) begin
			word_out_q <= res_word;
			acc_out_q  <= acc_n;
			ci_out_q   <= ci_n;
			halted_q   <= stop_n;
		end
	end

	assign out_valid           = out_valid_q;
	assign word_out            = word_out_q;
	assign accumulator_out     = acc_out_q;
	assign instruction_pointer = ci_out_q;
	assign halted              = halted_q;

	// store is written only when an item completes
	a_write_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_req.wr_en |-> done)
		else $error("store written outside item completion");

	// store read and write never fall in one cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		st_req.rd_en |-> !st_req.wr_en)
		else $error("store read and write in the same cycle");

	// a running fetch never starts on a halted machine
	a_fetch_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> !stop_q)
		else $error("fetch while halted");

	// a new result appears only after a completion
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done))
		else $error("result without completion");

endmodule
